@@ hw/rtl/hbec_pkg.sv @@
// shared types, character codes and utf-8 helpers for the html byte codec
package hbec_pkg;

    localparam int unsigned RES_MAX = 5;

    localparam logic [20:0] MAX_CODE  = 21'h10FFFF;
    localparam logic [20:0] REPL_CHAR = 21'h00FFFD;
    localparam logic [20:0] SURR_LO   = 21'h00D800;
    localparam logic [20:0] SURR_HI   = 21'h00DFFF;

    localparam logic [7:0] CH_AMP   = 8'h26;
    localparam logic [7:0] CH_LT    = 8'h3C;
    localparam logic [7:0] CH_GT    = 8'h3E;
    localparam logic [7:0] CH_QUOT  = 8'h22;
    localparam logic [7:0] CH_APOS  = 8'h27;
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_X_LO  = 8'h78;
    localparam logic [7:0] CH_X_UP  = 8'h58;

    typedef struct packed {
        logic [RES_MAX-1:0][7:0] bytes;
        logic [2:0]              cnt;
        logic                    last;
    } t_res;

    typedef struct packed {
        logic [3:0][7:0] b;
        logic [2:0]      len;
    } t_utf8;

    function automatic logic [15:0] cp1252_hi(input logic [4:0] idx);
        logic [15:0] r;
        case (idx)
            5'd0:  r = 16'h20AC;  5'd1:  r = 16'h0081;  5'd2:  r = 16'h201A;
            5'd3:  r = 16'h0192;  5'd4:  r = 16'h201E;  5'd5:  r = 16'h2026;
            5'd6:  r = 16'h2020;  5'd7:  r = 16'h2021;  5'd8:  r = 16'h02C6;
            5'd9:  r = 16'h2030;  5'd10: r = 16'h0160;  5'd11: r = 16'h2039;
            5'd12: r = 16'h0152;  5'd13: r = 16'h008D;  5'd14: r = 16'h017D;
            5'd15: r = 16'h008F;  5'd16: r = 16'h0090;  5'd17: r = 16'h2018;
            5'd18: r = 16'h2019;  5'd19: r = 16'h201C;  5'd20: r = 16'h201D;
            5'd21: r = 16'h2022;  5'd22: r = 16'h2013;  5'd23: r = 16'h2014;
            5'd24: r = 16'h02DC;  5'd25: r = 16'h2122;  5'd26: r = 16'h0161;
            5'd27: r = 16'h203A;  5'd28: r = 16'h0153;  5'd29: r = 16'h009D;
            5'd30: r = 16'h017E;  5'd31: r = 16'h0178;
            default: r = 16'h0000;
        endcase
        return r;
    endfunction

    function automatic t_utf8 utf8_encode(input logic [20:0] v_in, input logic ovf);
        logic [20:0] v;
        t_utf8       e;
        v = ovf ? REPL_CHAR : v_in;
        if (v >= 21'h80 && v <= 21'h9F) begin
            v = {5'd0, cp1252_hi(v[4:0])};
        end
        if (v == 21'd0 || v > MAX_CODE || (v >= SURR_LO && v <= SURR_HI)) begin
            v = REPL_CHAR;
        end
        e.b = '0;
        if (v <= 21'h7F) begin
            e.b[0] = v[7:0];
            e.len  = 3'd1;
        end else if (v <= 21'h7FF) begin
            e.b[0] = {3'b110, v[10:6]};
            e.b[1] = {2'b10, v[5:0]};
            e.len  = 3'd2;
        end else if (v <= 21'hFFFF) begin
            e.b[0] = {4'b1110, v[15:12]};
            e.b[1] = {2'b10, v[11:6]};
            e.b[2] = {2'b10, v[5:0]};
            e.len  = 3'd3;
        end else begin
            e.b[0] = {5'b11110, v[20:18]};
            e.b[1] = {2'b10, v[17:12]};
            e.b[2] = {2'b10, v[11:6]};
            e.b[3] = {2'b10, v[5:0]};
            e.len  = 3'd4;
        end
        return e;
    endfunction

endpackage

@@ hw/rtl/hbec_core.sv @@
// input register, reference decoder state and per-byte result builder
module hbec_core import hbec_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_dir,
    input  logic       i_cfg_wr,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [7:0] i_in_byte,
    input  logic       i_in_last,
    input  logic       i_res_free,
    output logic       o_res_valid,
    output t_res       o_res
);

    typedef enum logic [2:0] {
        PH_IDLE   = 3'd0,
        PH_AMP    = 3'd1,
        PH_HASH   = 3'd2,
        PH_HEX_LO = 3'd3,
        PH_DIGITS = 3'd4,
        PH_HEX_UP = 3'd5
    } t_phase;

    logic        r_in_valid;
    logic [7:0]  r_in_byte;
    logic        r_in_last;

    t_phase      r_phase, n_phase;
    logic        r_hex, n_hex;
    logic [20:0] r_code, n_code;
    logic        r_ovf, n_ovf;
    logic        r_seen, n_seen;

    logic        take;
    logic        is_dec, is_hex, in_radix;
    logic [3:0]  dval;
    logic [25:0] prod, sum;
    logic [20:0] upd_code;
    logic        upd_ovf;
    logic        use_cur;
    t_utf8       enc;

    logic [RES_MAX-1:0][7:0] a_b;
    logic [2:0]              a_len;
    logic                    mid_len;
    logic [3:0][7:0]         c_b;
    logic [2:0]              c_len;
    logic                    do_take, rerun;
    logic [3:0]              total;

    assign take        = r_in_valid && i_res_free;
    assign o_in_ready  = !r_in_valid || i_res_free;
    assign o_res_valid = take;

    // digit classification
    always_comb begin
        is_dec = (r_in_byte >= "0") && (r_in_byte <= "9");
        is_hex = is_dec || ((r_in_byte >= "a") && (r_in_byte <= "f"))
                        || ((r_in_byte >= "A") && (r_in_byte <= "F"));
        if (is_dec) begin
            dval = 4'(r_in_byte - "0");
        end else if (r_in_byte >= "a") begin
            dval = 4'(r_in_byte - "a" + 8'd10);
        end else begin
            dval = 4'(r_in_byte - "A" + 8'd10);
        end
        in_radix = r_hex ? is_hex : is_dec;
    end

    // accumulate one digit
    always_comb begin
        prod = r_hex ? {1'b0, r_code, 4'b0}
                     : ({2'b0, r_code, 3'b0} + {4'b0, r_code, 1'b0});
        sum  = prod + {22'd0, dval};
        upd_code = r_code;
        upd_ovf  = r_ovf;
        if (!r_ovf) begin
            if (sum > {5'd0, MAX_CODE}) begin
                upd_ovf = 1'b1;
            end else begin
                upd_code = sum[20:0];
            end
        end
    end

    assign use_cur = (r_phase == PH_DIGITS) && !in_radix;
    assign enc     = use_cur ? utf8_encode(r_code, r_ovf) : utf8_encode(upd_code, upd_ovf);

    always_comb begin
        a_b     = '0;
        a_len   = 3'd0;
        mid_len = 1'b0;
        c_b     = '0;
        c_len   = 3'd0;
        do_take = 1'b0;
        rerun   = 1'b0;
        n_phase = r_phase;
        n_hex   = r_hex;
        n_code  = r_code;
        n_ovf   = r_ovf;
        n_seen  = r_seen;

        if (!i_dir) begin
            case (r_in_byte)
                CH_AMP: begin
                    a_b = {";", "p", "m", "a", "&"};    a_len = 3'd5;
                end
                CH_LT: begin
                    a_b = {8'h00, ";", "t", "l", "&"};  a_len = 3'd4;
                end
                CH_GT: begin
                    a_b = {8'h00, ";", "t", "g", "&"};  a_len = 3'd4;
                end
                CH_QUOT: begin
                    a_b = {";", "4", "3", "#", "&"};    a_len = 3'd5;
                end
                CH_APOS: begin
                    a_b = {";", "9", "3", "#", "&"};    a_len = 3'd5;
                end
                default: begin
                    mid_len = 1'b1;
                end
            endcase
        end else begin
            case (r_phase)
                PH_AMP: begin
                    if (r_in_byte == CH_HASH) begin
                        n_phase = PH_HASH;
                    end else begin
                        a_b[0] = CH_AMP;  a_len = 3'd1;
                        rerun  = 1'b1;
                    end
                end
                PH_HASH: begin
                    if (r_in_byte == CH_X_LO || r_in_byte == CH_X_UP) begin
                        n_hex   = 1'b1;
                        n_phase = (r_in_byte == CH_X_LO) ? PH_HEX_LO : PH_HEX_UP;
                    end else if (is_dec) begin
                        do_take = 1'b1;
                    end else begin
                        a_b[0] = CH_AMP;  a_b[1] = CH_HASH;  a_len = 3'd2;
                        rerun  = 1'b1;
                    end
                end
                PH_HEX_LO, PH_HEX_UP: begin
                    if (is_hex) begin
                        do_take = 1'b1;
                    end else begin
                        a_b[0] = CH_AMP;
                        a_b[1] = CH_HASH;
                        a_b[2] = (r_phase == PH_HEX_LO) ? CH_X_LO : CH_X_UP;
                        a_len  = 3'd3;
                        rerun  = 1'b1;
                    end
                end
                PH_DIGITS: begin
                    if (in_radix) begin
                        do_take = 1'b1;
                    end else begin
                        a_b[3:0] = enc.b;
                        a_len    = enc.len;
                        n_phase  = PH_IDLE;
                        n_hex    = 1'b0;
                        n_code   = '0;
                        n_ovf    = 1'b0;
                        n_seen   = 1'b0;
                        rerun    = (r_in_byte != CH_SEMI);
                    end
                end
                default: begin
                    rerun = 1'b1;
                end
            endcase

            if (do_take) begin
                n_seen  = 1'b1;
                n_phase = PH_DIGITS;
                n_code  = upd_code;
                n_ovf   = upd_ovf;
            end

            if (rerun) begin
                n_hex  = 1'b0;
                n_code = '0;
                n_ovf  = 1'b0;
                n_seen = 1'b0;
                if (r_in_byte == CH_AMP) begin
                    n_phase = PH_AMP;
                end else begin
                    n_phase = PH_IDLE;
                    mid_len = 1'b1;
                end
            end

            // end of string flushes what is pending
            if (r_in_last) begin
                case (n_phase)
                    PH_AMP: begin
                        c_b[0] = CH_AMP;  c_len = 3'd1;
                    end
                    PH_HASH: begin
                        c_b[0] = CH_AMP;  c_b[1] = CH_HASH;  c_len = 3'd2;
                    end
                    PH_HEX_LO: begin
                        c_b[0] = CH_AMP;  c_b[1] = CH_HASH;  c_b[2] = CH_X_LO;
                        c_len  = 3'd3;
                    end
                    PH_HEX_UP: begin
                        c_b[0] = CH_AMP;  c_b[1] = CH_HASH;  c_b[2] = CH_X_UP;
                        c_len  = 3'd3;
                    end
                    PH_DIGITS: begin
                        c_b   = enc.b;
                        c_len = enc.len;
                    end
                    default: begin
                        c_len = 3'd0;
                    end
                endcase
                n_phase = PH_IDLE;
                n_hex   = 1'b0;
                n_code  = '0;
                n_ovf   = 1'b0;
                n_seen  = 1'b0;
            end
        end
    end

    // pack prefix, literal byte and flush text into the result lanes
    always_comb begin
        logic [3:0] idx;
        logic [3:0] k;
        total = {1'b0, a_len} + {3'd0, mid_len} + {1'b0, c_len};
        for (int i = 0; i < RES_MAX; i++) begin
            idx = 4'(i);
            k   = idx - {1'b0, a_len} - {3'd0, mid_len};
            if (idx < {1'b0, a_len}) begin
                o_res.bytes[i] = a_b[idx[2:0]];
            end else if (idx < ({1'b0, a_len} + {3'd0, mid_len})) begin
                o_res.bytes[i] = r_in_byte;
            end else begin
                o_res.bytes[i] = c_b[k[1:0]];
            end
        end
        o_res.cnt  = (total > 4'(RES_MAX)) ? 3'(RES_MAX) : total[2:0];
        o_res.last = r_in_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_phase    <= PH_IDLE;
            r_hex      <= 1'b0;
            r_code     <= '0;
            r_ovf      <= 1'b0;
            r_seen     <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (i_cfg_wr) begin
                r_phase <= PH_IDLE;
                r_hex   <= 1'b0;
                r_code  <= '0;
                r_ovf   <= 1'b0;
                r_seen  <= 1'b0;
            end else if (take) begin
                r_phase <= n_phase;
                r_hex   <= n_hex;
                r_code  <= n_code;
                r_ovf   <= n_ovf;
                r_seen  <= n_seen;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_byte <= i_in_byte;
            r_in_last <= i_in_last;
        end
    end

endmodule

@@ hw/rtl/hbec_out.sv @@
// result register that sends the bytes of one step one per transfer
module hbec_out import hbec_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_res_valid,
    input  t_res       i_res,
    output logic       o_res_free,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [7:0] o_out_byte,
    output logic       o_out_last,
    output logic       o_out_end
);

    logic [RES_MAX-1:0][7:0] r_bytes;
    logic [2:0]              r_left;
    logic                    r_end;

    assign o_out_valid = (r_left != 3'd0);
    assign o_out_byte  = r_bytes[0];
    assign o_out_last  = (r_left == 3'd1);
    assign o_out_end   = (r_left == 3'd1) && r_end;
    assign o_res_free  = (r_left == 3'd0) || ((r_left == 3'd1) && i_out_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left <= 3'd0;
        end else if (i_res_valid) begin
            r_left <= i_res.cnt;
        end else if (o_out_valid && i_out_ready) begin
            r_left <= r_left - 3'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_res_valid) begin
            r_bytes <= i_res.bytes;
            r_end   <= i_res.last;
        end else if (o_out_valid && i_out_ready) begin
            r_bytes <= {8'h00, r_bytes[RES_MAX-1:1]};
        end
    end

endmodule

@@ hw/rtl/html_byte_escape_codec_top.sv @@
// top level of the html byte escape / numeric reference decode codec
//
//   channel  dir  handshake                    payload
//   in       in   i_in_valid / o_in_ready      i_in_byte, i_in_last
//   out      out  o_out_valid / i_out_ready    o_out_byte, o_out_last, o_out_end
//   cfg      in   i_cfg_valid / o_cfg_ready    i_cfg_direction
//
// one input byte per cycle enters the input register while the result side is free,
// is decoded in one pass and lands in the result register; a step that yields n
// bytes holds that register until all n are sent, one per output transfer (0 to 5
// per input byte). output valid rises once a byte has passed both registers.
// synchronous reset clears direction to escape and drops any pending reference.
// a stalled output holds the result register and backs up into the input register.
module html_byte_escape_codec_top import hbec_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [7:0] i_in_byte,
    input  logic       i_in_last,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [7:0] o_out_byte,
    output logic       o_out_last,
    output logic       o_out_end,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic       i_cfg_direction
);

    logic r_dir;
    logic cfg_wr;
    logic res_valid;
    logic res_free;
    t_res res;

    assign o_cfg_ready = 1'b1;
    assign cfg_wr      = i_cfg_valid && o_cfg_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dir <= 1'b0;
        end else if (cfg_wr) begin
            r_dir <= i_cfg_direction;
        end
    end

    hbec_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_dir       (r_dir),
        .i_cfg_wr    (cfg_wr),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_byte   (i_in_byte),
        .i_in_last   (i_in_last),
        .i_res_free  (res_free),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    hbec_out u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_res_valid (res_valid),
        .i_res       (res),
        .o_res_free  (res_free),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_byte  (o_out_byte),
        .o_out_last  (o_out_last),
        .o_out_end   (o_out_end)
    );

endmodule

@@ hw/rtl/hbec_checker.sv @@
// port-level checks on the codec top, attached by bind
module hbec_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       o_in_ready,
    input logic [7:0] i_in_byte,
    input logic       i_in_last,
    input logic       o_out_valid,
    input logic       i_out_ready,
    input logic [7:0] o_out_byte,
    input logic       o_out_last,
    input logic       o_out_end,
    input logic       i_cfg_valid,
    input logic       o_cfg_ready,
    input logic       i_cfg_direction
);

    // output idle after reset
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid right after reset");

    // end of string only on the last byte of a step
    a_end_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_end |-> o_out_last)
        else $error("end flag without last flag");

    // a multi-byte result continues without a gap
    a_burst: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_ready && !o_out_last |=> o_out_valid)
        else $error("result bytes broken off");

    // with nothing to send the input side is open
    a_in_open: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("input blocked while output empty");

    // stalled output transfer holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_byte)
            && $stable(o_out_last) && $stable(o_out_end))
        else $error("stalled output changed");

endmodule

bind html_byte_escape_codec_top hbec_checker u_chk (.*);
